@@ design/ifd_pkg.sv @@
// ----------------------------------------------------------------------------
// ifd_pkg
// Shared types and character constants for the in-band file transfer deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package ifd_pkg;

    localparam int unsigned CHAR_W    = 7;
    localparam int unsigned BURST_MAX = 7;
    localparam int unsigned IDX_W     = 3;

    localparam logic [CHAR_W-1:0] CH_CR    = 7'h0D;
    localparam logic [CHAR_W-1:0] CH_LF    = 7'h0A;
    localparam logic [CHAR_W-1:0] CH_TILDE = 7'h7E;
    localparam logic [CHAR_W-1:0] CH_GT    = 7'h3E;
    localparam logic [CHAR_W-1:0] CH_COLON = 7'h3A;
    localparam logic [CHAR_W-1:0] CH_SP    = 7'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 7'h09;
    localparam logic [CHAR_W-1:0] CH_O     = 7'h6F;
    localparam logic [CHAR_W-1:0] CH_K     = 7'h6B;
    localparam logic [CHAR_W-1:0] CH_NUL   = 7'h00;

    typedef enum logic [2:0] {
        K_CON    = 3'd0,
        K_FILE   = 3'd1,
        K_NAME   = 3'd2,
        K_CREATE = 3'd3,
        K_APPEND = 3'd4,
        K_CLOSE  = 3'd5
    } kind_t;

    typedef enum logic [3:0] {
        ST_CONSOLE       = 4'd0,
        ST_CR            = 4'd1,
        ST_CR_TILDE      = 4'd2,
        ST_CR_TILDE_GT   = 4'd3,
        ST_APPEND_GT     = 4'd4,
        ST_BLANKS        = 4'd5,
        ST_NAME          = 4'd6,
        ST_BODY          = 4'd7,
        ST_BODY_CR       = 4'd8,
        ST_BODY_CR_TILDE = 4'd9
    } state_t;

    // Results caused by one received byte, in emission order.
    typedef struct packed {
        logic [BURST_MAX-1:0][CHAR_W-1:0] chars;
        kind_t [BURST_MAX-1:0]            kinds;
        logic [IDX_W-1:0]                 cnt;
    } burst_t;

    // Buffer status toward the input side.
    typedef struct packed {
        logic free;
        logic busy;
    } buf_status_t;

    function automatic burst_t put(burst_t b, logic [CHAR_W-1:0] ch, kind_t k);
        burst_t r;
        r = b;
        r.chars[b.cnt] = ch;
        r.kinds[b.cnt] = k;
        r.cnt = b.cnt + 3'd1;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ design/ifd_in_if.sv @@
// ----------------------------------------------------------------------------
// ifd_in_if
// Received serial byte channel: valid/ready plus the raw byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface ifd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

@@ design/ifd_out_if.sv @@
// ----------------------------------------------------------------------------
// ifd_out_if
// Result channel: valid/ready plus character, kind and last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface ifd_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_char;
    logic [2:0] out_kind;
    logic       last;

    modport source (output valid, output out_char, output out_kind, output last,
                    input ready);
    modport sink   (input valid, input out_char, input out_kind, input last,
                    output ready);
endinterface

`default_nettype wire

@@ design/ifd_recognizer.sv @@
// ----------------------------------------------------------------------------
// ifd_recognizer
// Frame recognizer: state registers and the burst of words one byte causes.
// ----------------------------------------------------------------------------
`default_nettype none

module ifd_recognizer
    import ifd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] rx_byte,
    output burst_t          burst
);

    state_t            state_reg, state_next;
    logic              append_reg, append_next;
    logic              crp_reg, crp_next;
    logic [CHAR_W-1:0] c;
    burst_t            b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CONSOLE;
            append_reg <= 1'b0;
            crp_reg    <= 1'b0;
        end
        else if (accept)
        begin
            state_reg  <= state_next;
            append_reg <= append_next;
            crp_reg    <= crp_next;
        end
    end

    always_comb
    begin
        c           = rx_byte[CHAR_W-1:0];   // parity bit dropped
        b           = '0;
        state_next  = state_reg;
        append_next = append_reg;
        crp_next    = crp_reg;
        case (state_reg)
            ST_CR:
            begin
                if (c == CH_TILDE)
                    state_next = ST_CR_TILDE;
                else if (c == CH_CR)
                    b = put(b, CH_CR, K_CON);
                else
                begin
                    state_next = ST_CONSOLE;
                    b = put(b, CH_CR, K_CON);
                    b = put(b, c, K_CON);
                end
            end
            ST_CR_TILDE:
            begin
                if (c == CH_GT)
                    state_next = ST_CR_TILDE_GT;
                else
                begin
                    state_next = ST_CONSOLE;
                    b = put(b, CH_CR, K_CON);
                    b = put(b, CH_TILDE, K_CON);
                    b = put(b, c, K_CON);
                end
            end
            ST_CR_TILDE_GT:
            begin
                if (c == CH_GT)
                    state_next = ST_APPEND_GT;
                else if (c == CH_COLON)
                begin
                    state_next  = ST_BLANKS;
                    append_next = 1'b0;
                end
                else
                begin
                    state_next = ST_CONSOLE;
                    b = put(b, CH_CR, K_CON);
                    b = put(b, CH_TILDE, K_CON);
                    b = put(b, CH_GT, K_CON);
                    b = put(b, c, K_CON);
                end
            end
            ST_APPEND_GT:
            begin
                if (c == CH_COLON)
                begin
                    state_next  = ST_BLANKS;
                    append_next = 1'b1;
                end
                else
                begin
                    state_next = ST_CONSOLE;
                    b = put(b, CH_CR, K_CON);
                    b = put(b, CH_TILDE, K_CON);
                    b = put(b, CH_GT, K_CON);
                    b = put(b, CH_GT, K_CON);
                    b = put(b, c, K_CON);
                end
            end
            ST_BLANKS:
            begin
                if (c == CH_CR)
                begin
                    // empty filename: replay the header, less its blanks
                    state_next = ST_CONSOLE;
                    b = put(b, CH_CR, K_CON);
                    b = put(b, CH_TILDE, K_CON);
                    b = put(b, CH_GT, K_CON);
                    if (append_reg)
                        b = put(b, CH_GT, K_CON);
                    b = put(b, CH_COLON, K_CON);
                    b = put(b, CH_CR, K_CON);
                end
                else if (c != CH_SP && c != CH_TAB)
                begin
                    state_next = ST_NAME;
                    b = put(b, c, K_NAME);
                end
            end
            ST_NAME:
            begin
                if (c == CH_CR)
                begin
                    crp_next   = 1'b1;
                    state_next = ST_BODY;
                    b = put(b, CH_NUL, append_reg ? K_APPEND : K_CREATE);
                end
                else
                    b = put(b, c, K_NAME);
            end
            ST_BODY:
            begin
                if (c == CH_CR)
                begin
                    crp_next   = 1'b1;
                    state_next = ST_BODY_CR;
                end
                else if (c == CH_LF && crp_reg)
                    crp_next = 1'b0;
                else
                    b = put(b, c, K_FILE);
            end
            ST_BODY_CR:
            begin
                if (c == CH_TILDE)
                    state_next = ST_BODY_CR_TILDE;
                else if (c == CH_LF && crp_reg)
                begin
                    crp_next   = 1'b0;
                    state_next = ST_BODY;
                    b = put(b, CH_LF, K_FILE);
                end
                else
                begin
                    state_next = ST_BODY;
                    b = put(b, CH_CR, K_FILE);
                    b = put(b, c, K_FILE);
                end
            end
            ST_BODY_CR_TILDE:
            begin
                if (c == CH_GT)
                begin
                    state_next = ST_CONSOLE;
                    b = put(b, CH_NUL, K_CLOSE);
                    b = put(b, CH_CR, K_CON);
                    b = put(b, CH_LF, K_CON);
                    b = put(b, CH_O, K_CON);
                    b = put(b, CH_K, K_CON);
                    b = put(b, CH_CR, K_CON);
                    b = put(b, CH_LF, K_CON);
                end
                else
                begin
                    state_next = ST_BODY;
                    b = put(b, CH_CR, K_FILE);
                    b = put(b, CH_TILDE, K_FILE);
                    b = put(b, c, K_FILE);
                end
            end
            default:
            begin
                state_next = ST_CONSOLE;
                if (c == CH_CR)
                    state_next = ST_CR;
                else
                    b = put(b, c, K_CON);
            end
        endcase
    end

    assign burst = b;

endmodule

`default_nettype wire

@@ design/ifd_burst_buffer.sv @@
// ----------------------------------------------------------------------------
// ifd_burst_buffer
// Result register holding one byte's burst; hands out one word a cycle while ready.
// ----------------------------------------------------------------------------
`default_nettype none

module ifd_burst_buffer
    import ifd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   load,
    input  wire burst_t burst,
    output buf_status_t status,
    ifd_out_if.source   result
);

    logic [BURST_MAX-1:0][CHAR_W-1:0] chars_reg;
    kind_t [BURST_MAX-1:0]            kinds_reg;
    logic [IDX_W-1:0]                 idx_reg;
    logic [IDX_W-1:0]                 rem_reg;
    logic                             take;

    assign take = result.valid && result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            rem_reg <= '0;
        end
        else if (load)
        begin
            idx_reg <= '0;
            rem_reg <= burst.cnt;
        end
        else if (take)
        begin
            idx_reg <= idx_reg + 3'd1;
            rem_reg <= rem_reg - 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            chars_reg <= burst.chars;
            kinds_reg <= burst.kinds;
        end
    end

    assign status.busy = (rem_reg != '0);
    // free when empty or the final word leaves this cycle
    assign status.free = (rem_reg == '0) || (rem_reg == 3'd1 && result.ready);

    assign result.valid    = status.busy;
    assign result.out_char = chars_reg[idx_reg];
    assign result.out_kind = kinds_reg[idx_reg];
    assign result.last     = (rem_reg == 3'd1);

endmodule

`default_nettype wire

@@ design/inband_file_transfer_deframer.sv @@
// ----------------------------------------------------------------------------
// inband_file_transfer_deframer
// Strips parity from received bytes and splits the stream into console,
// filename and file words plus open/close events for CR~>[>]: name CR frames.
// ----------------------------------------------------------------------------
//
//   port    dir    fields                      meaning
//   serial  sink   rx_byte[7:0]                received byte, bit 7 = parity
//   result  source out_char[6:0] out_kind[2:0] one word per emitted result,
//                  last                        last marks a byte's final word
//
// Cycles: a byte is decoded in the cycle it is accepted and its 0..7 words
// land in the result register; the first is offered on the next cycle.
// A byte causing n words holds the output until all n have left, one word a
// cycle while result.ready is high; the next byte is taken in the cycle the
// last word leaves; while ready, bytes of at most one word flow one per cycle.
// Bytes that cause no word are absorbed with no output.
// Reset clears the recognizer state, append and CR flags, and the word count.
// A stalled result freezes its word; serial.ready stays low until it goes.
// ----------------------------------------------------------------------------
`default_nettype none

module inband_file_transfer_deframer
    import ifd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    ifd_in_if.sink    serial,
    ifd_out_if.source result
);

    burst_t      burst;
    buf_status_t status;
    logic        accept;

    assign serial.ready = status.free;
    assign accept       = serial.valid && status.free;

    // recognizer state advances only on accepted bytes
    ifd_recognizer u_recognizer (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (serial.rx_byte),
        .burst   (burst)
    );

    // result register and word sequencer
    ifd_burst_buffer u_buffer (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (accept),
        .burst  (burst),
        .status (status),
        .result (result)
    );

`ifndef SYNTHESIS
    // never take a byte while more than the departing word is still queued
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (!status.busy || (result.ready && result.last)))
        else $error("byte accepted over pending words");

    // after a burst's final word, output only resumes with a new byte
    a_burst_end: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.ready && result.last && !accept) |=> !result.valid)
        else $error("word emitted with no byte behind it");

    // close is always followed by the console CR of the ok banner
    a_close_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.ready && result.out_kind == K_CLOSE) |=>
        (result.valid && result.out_char == CH_CR && result.out_kind == K_CON))
        else $error("close not followed by ok banner");

    // events carry no character
    a_event_char: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.out_kind == K_CREATE || result.out_kind == K_APPEND
                          || result.out_kind == K_CLOSE)) |-> result.out_char == CH_NUL)
        else $error("event word with nonzero character");
`endif

endmodule

`default_nettype wire
